// ===== hw/rtl/csb_pkg.sv =====
// Shared constants and types for the cascaded stencil blur.
`timescale 1ns / 1ps

package csb_pkg;

    // Pixel and marker
    localparam int PIXEL_W = 8;
    localparam logic [PIXEL_W-1:0] IGNORE_MARK = 8'd253;

    // Line buffer depth default
    localparam int MAX_LINE_DEF = 1024;

    // Configuration register widths and reset values
    localparam int LINE_WIDTH_W   = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_INDEX_W    = 1;
    localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RST   = 11'd4;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd4;

    // Row counter
    localparam int ROW_W = 12;
    localparam logic [FRAME_HEIGHT_W-1:0] ROWS_MAX = 13'd4096;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LINE_WIDTH   = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    // Image-edge conditions for the current pixel position
    typedef struct packed {
        logic row_lt2;
        logic col_lt2;
        logic row_lt1;
        logic col_lt1;
    } edge_flags_t;

endpackage

// ===== hw/rtl/cascaded_stencil_blur_top.sv =====
// Cascaded 3x3 / 2x2 causal blur: line buffers, window stage and output register.
// Each accepted pixel moves from the window stage register to the output register.
// Throughput: one pixel per cycle unless out_stall holds the output; the line-buffer
// RAM read is issued at accept, and window stage and output register hold one each.
// Reset: position counters clear to zero, line_width and frame_height return to 4;
// line buffers and window registers are not cleared.
`timescale 1ns / 1ps

module cascaded_stencil_blur_top #(
    parameter int MAX_LINE = csb_pkg::MAX_LINE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [csb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [csb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [csb_pkg::PIXEL_W-1:0]      pixel,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [csb_pkg::PIXEL_W-1:0]      filtered
);

    localparam int CW = $clog2(MAX_LINE);
    localparam int PW = csb_pkg::PIXEL_W;
    localparam int LW = 3 * PW;

    logic                 accept;
    logic                 advance;
    logic [CW-1:0]        col;
    csb_pkg::edge_flags_t flags;

    // Window stage registers
    logic                 s1_valid_reg;
    logic [PW-1:0]        s1_pix_reg;
    logic [CW-1:0]        s1_idx_reg;
    csb_pkg::edge_flags_t s1_flags_reg;

    // Same-address bypass around the line-buffer RAM
    logic                 fwd_reg;
    logic [LW-1:0]        fwd_data_reg;

    // Output register
    logic                 out_valid_reg;
    logic [PW-1:0]        filtered_reg;

    logic [LW-1:0]        line_rdata;
    logic [LW-1:0]        line_q;
    logic [LW-1:0]        line_wdata;
    logic [PW-1:0]        top_pix;
    logic [PW-1:0]        mid_pix;
    logic [PW-1:0]        blur_above;
    logic [PW-1:0]        blur;
    logic [PW-1:0]        result;

    // Handshake
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    csb_pos #(
        .MAX_LINE (MAX_LINE)
    ) u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .col       (col),
        .flags     (flags)
    );

    // Line buffers: {blur row above, pixel row two above, pixel row above}
    csb_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_LINE)
    ) u_line_ram (
        .clk   (clk),
        .we    (advance),
        .waddr (s1_idx_reg),
        .wdata (line_wdata),
        .re    (accept),
        .raddr (col),
        .rdata (line_rdata)
    );

    assign line_q     = fwd_reg ? fwd_data_reg : line_rdata;
    assign mid_pix    = line_q[PW-1:0];
    assign top_pix    = line_q[2*PW-1:PW];
    assign blur_above = line_q[3*PW-1:2*PW];
    assign line_wdata = {blur, mid_pix, s1_pix_reg};

    // Window stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Window stage payload and bypass capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= pixel;
            s1_idx_reg   <= col;
            s1_flags_reg <= flags;
            fwd_reg      <= advance && (s1_idx_reg == col);
            fwd_data_reg <= line_wdata;
        end
    end

    csb_filter u_filter (
        .clk        (clk),
        .advance    (advance),
        .pix        (s1_pix_reg),
        .top_pix    (top_pix),
        .mid_pix    (mid_pix),
        .blur_above (blur_above),
        .flags      (s1_flags_reg),
        .blur       (blur),
        .result     (result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            filtered_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

endmodule

// ===== hw/rtl/csb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module csb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port (returns old data on a same-address write)
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/csb_pos.sv =====
// Configuration registers and raster position counters.
`timescale 1ns / 1ps

module csb_pos #(
    parameter int MAX_LINE = csb_pkg::MAX_LINE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [csb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [csb_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                accept,
    output logic [$clog2(MAX_LINE)-1:0]         col,
    output csb_pkg::edge_flags_t                flags
);

    localparam int CW   = $clog2(MAX_LINE);
    localparam int CMPW = (CW + 1 > 12) ? CW + 1 : 12;

    logic [csb_pkg::LINE_WIDTH_W-1:0]   line_width_reg;
    logic [csb_pkg::FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic [CW-1:0]                      col_reg;
    logic [CW-1:0]                      col_next;
    logic [csb_pkg::ROW_W-1:0]          row_reg;
    logic [csb_pkg::ROW_W-1:0]          row_next;
    logic [CMPW-1:0]                    width_lim;
    logic [CMPW-1:0]                    width_eff;
    logic [csb_pkg::FRAME_HEIGHT_W-1:0] height_eff;
    logic [CMPW-1:0]                    col_inc;
    logic [csb_pkg::FRAME_HEIGHT_W-1:0] row_inc;

    // Register write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= csb_pkg::LINE_WIDTH_RST;
            frame_height_reg <= csb_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (csb_pkg::cfg_index_t'(cfg_index))
                csb_pkg::CFG_LINE_WIDTH:
                    line_width_reg <= cfg_data[csb_pkg::LINE_WIDTH_W-1:0];
                csb_pkg::CFG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data[csb_pkg::FRAME_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the settings into their usable range
    always_comb
    begin
        width_lim = CMPW'(MAX_LINE);
        if (line_width_reg == '0)
            width_eff = CMPW'(1);
        else if (CMPW'(line_width_reg) > width_lim)
            width_eff = width_lim;
        else
            width_eff = CMPW'(line_width_reg);

        if (frame_height_reg == '0)
            height_eff = csb_pkg::FRAME_HEIGHT_W'(1);
        else if (frame_height_reg > csb_pkg::ROWS_MAX)
            height_eff = csb_pkg::ROWS_MAX;
        else
            height_eff = frame_height_reg;
    end

    // Next position; wraps at or beyond the last column / row
    always_comb
    begin
        col_inc  = CMPW'(col_reg) + CMPW'(1);
        row_inc  = csb_pkg::FRAME_HEIGHT_W'(row_reg) + csb_pkg::FRAME_HEIGHT_W'(1);
        col_next = col_inc[CW-1:0];
        row_next = row_reg;
        if (col_inc >= width_eff)
        begin
            col_next = '0;
            if (row_inc >= height_eff)
                row_next = '0;
            else
                row_next = row_inc[csb_pkg::ROW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Position of the pixel being accepted
    assign col           = col_reg;
    assign flags.row_lt2 = (row_reg < csb_pkg::ROW_W'(2));
    assign flags.col_lt2 = (col_reg < CW'(2));
    assign flags.row_lt1 = (row_reg == '0);
    assign flags.col_lt1 = (col_reg == '0);

endmodule

// ===== hw/rtl/csb_filter.sv =====
// Window registers and the two blur kernels for one pixel position.
`timescale 1ns / 1ps

module csb_filter (
    input  logic                              clk,
    input  logic                              advance,
    input  logic [csb_pkg::PIXEL_W-1:0]       pix,
    input  logic [csb_pkg::PIXEL_W-1:0]       top_pix,
    input  logic [csb_pkg::PIXEL_W-1:0]       mid_pix,
    input  logic [csb_pkg::PIXEL_W-1:0]       blur_above,
    input  csb_pkg::edge_flags_t              flags,
    output logic [csb_pkg::PIXEL_W-1:0]       blur,
    output logic [csb_pkg::PIXEL_W-1:0]       result
);

    localparam int PW = csb_pkg::PIXEL_W;

    // Two previous columns of the three pixel rows, previous column of blur rows
    logic [PW-1:0] pwin_reg [6];
    logic [PW-1:0] bwin_reg [2];

    logic [PW+3:0] sum3;
    logic          hit3;
    logic [PW+2:0] sum2;
    logic          hit2;

    // Stage one: 1 2 1 / 2 4 2 / 1 2 1, divided by 16
    always_comb
    begin
        sum3 = {4'b0, pwin_reg[0]} + {3'b0, pwin_reg[1], 1'b0} + {4'b0, top_pix}
             + {3'b0, pwin_reg[2], 1'b0} + {2'b0, pwin_reg[3], 2'b0}
             + {3'b0, mid_pix, 1'b0}
             + {4'b0, pwin_reg[4]} + {3'b0, pwin_reg[5], 1'b0} + {4'b0, pix};
        hit3 = (pwin_reg[0] == csb_pkg::IGNORE_MARK) || (pwin_reg[1] == csb_pkg::IGNORE_MARK)
            || (top_pix == csb_pkg::IGNORE_MARK)     || (pwin_reg[2] == csb_pkg::IGNORE_MARK)
            || (pwin_reg[3] == csb_pkg::IGNORE_MARK) || (mid_pix == csb_pkg::IGNORE_MARK)
            || (pwin_reg[4] == csb_pkg::IGNORE_MARK) || (pwin_reg[5] == csb_pkg::IGNORE_MARK)
            || (pix == csb_pkg::IGNORE_MARK);
        if (flags.row_lt2 || flags.col_lt2 || hit3)
            blur = csb_pkg::IGNORE_MARK;
        else
            blur = sum3[PW+3:4];
    end

    // Stage two: 1 4 / 2 1 on the blurred values, divided by 8
    always_comb
    begin
        sum2 = {3'b0, bwin_reg[0]} + {1'b0, blur_above, 2'b0}
             + {2'b0, bwin_reg[1], 1'b0} + {3'b0, blur};
        hit2 = (bwin_reg[0] == csb_pkg::IGNORE_MARK) || (blur_above == csb_pkg::IGNORE_MARK)
            || (bwin_reg[1] == csb_pkg::IGNORE_MARK) || (blur == csb_pkg::IGNORE_MARK);
        if (flags.row_lt1 || flags.col_lt1 || hit2)
            result = csb_pkg::IGNORE_MARK;
        else
            result = sum2[PW+2:3];
    end

    // Shift the windows when the pixel leaves this stage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pwin_reg[0] <= pwin_reg[1];
            pwin_reg[1] <= top_pix;
            pwin_reg[2] <= pwin_reg[3];
            pwin_reg[3] <= mid_pix;
            pwin_reg[4] <= pwin_reg[5];
            pwin_reg[5] <= pix;
            bwin_reg[0] <= blur_above;
            bwin_reg[1] <= blur;
        end
    end

endmodule
